// ----- design/ryc_pkg.sv -----
package ryc_pkg;

    localparam int CFG_W = 13;
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;

    localparam logic [CFG_W-1:0] LINE_WIDTH_RST   = 13'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 13'd480;

    localparam logic REG_LINE_WIDTH   = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_U    = 2'd1,
        KIND_V    = 2'd2
    } t_chroma_kind;

    typedef struct packed {
        t_chroma_kind kind;
        logic         frame_last;
    } t_raster_tag;

    typedef logic signed [17:0] t_acc;

    function automatic logic [7:0] scale_sample(input t_acc sum, input logic [7:0] bias);
        t_acc shifted;
        shifted = (sum + 18'sd128) >>> 8;
        return shifted[7:0] + bias;
    endfunction

endpackage

// ----- design/ryc_if.sv -----
interface ryc_rgb_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;

    modport source (output valid, output red, output green, output blue, input ready);
    modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface ryc_yuv_if;
    logic       valid;
    logic       ready;
    logic [7:0] luma;
    logic [7:0] chroma;
    logic [1:0] chroma_kind;
    logic       frame_last;

    modport source (output valid, output luma, output chroma, output chroma_kind,
                    output frame_last, input ready);
    modport sink   (input valid, input luma, input chroma, input chroma_kind,
                    input frame_last, output ready);
endinterface

// ----- design/rgb_to_yuv420_converter_core.sv -----
// RGB24 to YUV 4:2:0 stream converter, BT.601 limited range.
// i_pix takes one RGB pixel per transaction in raster order; o_yuv returns
// one transaction per pixel with luma, and with a U sample on even columns of
// even rows or a V sample on even columns of odd rows (chroma_kind tags it,
// chroma reads 0 on odd columns). frame_last marks the last pixel of a frame.
// line_width (0x0) and frame_height (0x4) are written over the APB port while
// the stream is idle; 0 acts as 1, values above MAX_DIMENSION act as it.
// An accepted pixel passes the input register, then the color matrix into the
// result register, which presents it on o_yuv. Throughput: one pixel per cycle
// unless the receiver stalls, set by the two-register pipeline (input
// register, then result register after the color matrix).
// When the receiver stalls, the result register holds and the input register
// takes one more pixel; i_pix.ready drops once both are full.
// Reset clears the pipeline, the raster position and restores 640x480.
module rgb_to_yuv420_converter_core
    import ryc_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    ryc_rgb_if.sink               i_pix,
    ryc_yuv_if.source             o_yuv,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [CFG_W-1:0] r_line_width;
    logic [CFG_W-1:0] r_frame_height;
    logic             cfg_write;

    logic             r_v1;
    logic             r_v2;
    logic             accept;
    logic             adv1;
    t_raster_tag      tag;
    t_raster_tag      r_tag1;
    logic [7:0]       r_red;
    logic [7:0]       r_green;
    logic [7:0]       r_blue;
    logic [7:0]       luma;
    logic [7:0]       cb;
    logic [7:0]       cr;
    logic [7:0]       r_luma;
    logic [7:0]       r_chroma;
    t_chroma_kind     r_kind;
    logic             r_last;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            REG_LINE_WIDTH:   prdata = APB_DATA_W'(r_line_width);
            REG_FRAME_HEIGHT: prdata = APB_DATA_W'(r_frame_height);
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_width   <= LINE_WIDTH_RST;
            r_frame_height <= FRAME_HEIGHT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_LINE_WIDTH) begin
                r_line_width <= pwdata[CFG_W-1:0];
            end else begin
                r_frame_height <= pwdata[CFG_W-1:0];
            end
        end
    end

    assign adv1        = !r_v2 || o_yuv.ready;
    assign i_pix.ready = !r_v1 || adv1;
    assign accept      = i_pix.valid && i_pix.ready;

    ryc_raster #(
        .MAX_DIMENSION(MAX_DIMENSION)
    ) u_raster (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_advance      (accept),
        .i_line_width   (r_line_width),
        .i_frame_height (r_frame_height),
        .o_tag          (tag)
    );

    ryc_csc u_csc (
        .i_red   (r_red),
        .i_green (r_green),
        .i_blue  (r_blue),
        .o_luma  (luma),
        .o_cb    (cb),
        .o_cr    (cr)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (accept) begin
                r_v1 <= 1'b1;
            end else if (adv1) begin
                r_v1 <= 1'b0;
            end
            if (adv1) begin
                r_v2 <= r_v1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_red   <= i_pix.red;
            r_green <= i_pix.green;
            r_blue  <= i_pix.blue;
            r_tag1  <= tag;
        end
        if (adv1 && r_v1) begin
            r_luma <= luma;
            r_kind <= r_tag1.kind;
            r_last <= r_tag1.frame_last;
            case (r_tag1.kind)
                KIND_U:  r_chroma <= cb;
                KIND_V:  r_chroma <= cr;
                default: r_chroma <= 8'd0;
            endcase
        end
    end

    assign o_yuv.valid       = r_v2;
    assign o_yuv.luma        = r_luma;
    assign o_yuv.chroma      = r_chroma;
    assign o_yuv.chroma_kind = r_kind;
    assign o_yuv.frame_last  = r_last;

    a_no_chroma_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_yuv.valid && o_yuv.chroma_kind == KIND_NONE) |-> o_yuv.chroma == 8'd0)
        else $error("chroma not zero on a luma-only transaction");

    a_luma_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_yuv.valid |-> (o_yuv.luma >= 8'd16 && o_yuv.luma <= 8'd235))
        else $error("luma outside limited range");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && !o_yuv.ready) |-> !i_pix.ready)
        else $error("input taken with both pipeline registers full");

    a_stage_move: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && adv1) |=> r_v2)
        else $error("pipeline dropped a pixel");

endmodule

// ----- design/ryc_csc.sv -----
module ryc_csc
    import ryc_pkg::*;
(
    input  logic [7:0] i_red,
    input  logic [7:0] i_green,
    input  logic [7:0] i_blue,
    output logic [7:0] o_luma,
    output logic [7:0] o_cb,
    output logic [7:0] o_cr
);

    t_acc r;
    t_acc g;
    t_acc b;
    t_acc sum_y;
    t_acc sum_u;
    t_acc sum_v;

    assign r = $signed({10'b0, i_red});
    assign g = $signed({10'b0, i_green});
    assign b = $signed({10'b0, i_blue});

    assign sum_y = 18'sd66 * r + 18'sd129 * g + 18'sd25 * b;
    assign sum_u = 18'sd112 * b - 18'sd38 * r - 18'sd74 * g;
    assign sum_v = 18'sd112 * r - 18'sd94 * g - 18'sd18 * b;

    assign o_luma = scale_sample(sum_y, 8'd16);
    assign o_cb   = scale_sample(sum_u, 8'd128);
    assign o_cr   = scale_sample(sum_v, 8'd128);

endmodule

// ----- design/ryc_raster.sv -----
module ryc_raster
    import ryc_pkg::*;
#(
    parameter int MAX_DIMENSION = 4096
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_advance,
    input  logic [CFG_W-1:0] i_line_width,
    input  logic [CFG_W-1:0] i_frame_height,
    output t_raster_tag      o_tag
);

    localparam int CNT_W = $clog2(MAX_DIMENSION);
    localparam int EW    = (CNT_W + 1 > CFG_W) ? CNT_W + 1 : CFG_W;
    localparam logic [EW-1:0] MAX_DIM = EW'(MAX_DIMENSION);

    logic [CNT_W-1:0] r_col;
    logic [CNT_W-1:0] r_row;
    logic [CNT_W-1:0] n_col;
    logic [CNT_W-1:0] n_row;
    logic [EW-1:0]    w_eff;
    logic [EW-1:0]    h_eff;
    logic             row_end;
    logic             frame_end;

    always_comb begin
        if (i_line_width == '0) begin
            w_eff = EW'(1);
        end else if (EW'(i_line_width) > MAX_DIM) begin
            w_eff = MAX_DIM;
        end else begin
            w_eff = EW'(i_line_width);
        end
        if (i_frame_height == '0) begin
            h_eff = EW'(1);
        end else if (EW'(i_frame_height) > MAX_DIM) begin
            h_eff = MAX_DIM;
        end else begin
            h_eff = EW'(i_frame_height);
        end
    end

    assign row_end   = (EW'(r_col) + EW'(1)) >= w_eff;
    assign frame_end = row_end && ((EW'(r_row) + EW'(1)) >= h_eff);

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_advance) begin
            if (row_end) begin
                n_col = '0;
                n_row = frame_end ? '0 : r_row + CNT_W'(1);
            end else begin
                n_col = r_col + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_comb begin
        o_tag.frame_last = frame_end;
        if (r_col[0]) begin
            o_tag.kind = KIND_NONE;
        end else if (r_row[0]) begin
            o_tag.kind = KIND_V;
        end else begin
            o_tag.kind = KIND_U;
        end
    end

endmodule
